### design/segment_lcd_three_wire_frame_tx_defines.svh
// Assertion macros shared by the checker of the three-wire LCD frame transmitter.
// No dependencies; included by the checker file only.
`ifndef SEGMENT_LCD_THREE_WIRE_FRAME_TX_DEFINES_SVH
`define SEGMENT_LCD_THREE_WIRE_FRAME_TX_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define SL3WTX_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// ante at one edge implies cons at the same edge
`define SL3WTX_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

### design/sl3wtx_pkg.sv
// Types and constants of the three-wire LCD frame transmitter.
// No dependencies; used by every module of the block.
package sl3wtx_pkg;

   localparam int CNT_W         = 4;   // widest phase is the 12-bit command body
   localparam int ADDR_MAX_BITS = 8;   // widest address the bus can carry
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [2:0] ID_COMMAND = 3'b100;
   localparam logic [2:0] ID_WRITE   = 3'b101;
   localparam logic [2:0] ID_READ    = 3'b110;

   typedef enum logic [1:0] {
      FN_CMD    = 2'd0,
      FN_WRITE  = 2'd1,
      FN_READ   = 2'd2,
      FN_SAMPLE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      FR_NONE      = 2'd0,
      FR_WRITE     = 2'd1,
      FR_READ_IDLE = 2'd2,
      FR_READ_WAIT = 2'd3
   } frame_type;

   typedef enum logic [1:0] {
      JOB_CMD    = 2'd0,
      JOB_WRITE  = 2'd1,
      JOB_READ   = 2'd2,
      JOB_NIBBLE = 2'd3
   } job_kind_type;

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_READ    = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_NIBBLE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_PRE  = 3'd1,
      PH_ID   = 3'd2,
      PH_ADDR = 3'd3,
      PH_BODY = 3'd4,
      PH_POST = 3'd5
   } phase_type;

   // one classified item, handed from front to back
   typedef struct packed {
      logic         pre_rel;   // release the open frame first
      logic         hdr;       // send id and address
      logic         post_rel;  // release chip select at the end
      job_kind_type kind;
      logic [5:0]   addr;
      logic [7:0]   data;      // command, byte, or nibble in the low bits
      logic         both;
   } job_type;

endpackage

### design/sl3wtx_front.sv
// Front end: accepts items, tracks the open frame and the read samples, emits jobs.
// Depends on sl3wtx_pkg.
module sl3wtx_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           func,
   input  logic [7:0]           command_code,
   input  logic [5:0]           ram_address,
   input  logic [7:0]           data_byte,
   input  logic                 both_halves,
   input  logic                 sample_bit,
   input  logic                 last_item,
   output logic                 push,
   output sl3wtx_pkg::job_type  job
);

   sl3wtx_pkg::frame_type open_ff, open_in;
   logic [3:0]            shift_ff, shift_in;
   logic [1:0]            count_ff, count_in;
   logic [3:0]            shift_next;
   logic                  is_open;

   assign is_open    = (open_ff != sl3wtx_pkg::FR_NONE);
   assign shift_next = shift_ff | (4'(sample_bit) << count_ff);

   always_comb begin
      open_in      = open_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      push         = 1'b0;
      job.pre_rel  = 1'b0;
      job.hdr      = 1'b0;
      job.post_rel = 1'b0;
      job.kind     = sl3wtx_pkg::JOB_CMD;
      job.addr     = ram_address;
      job.data     = data_byte;
      job.both     = both_halves;
      if (accept) begin
         case (sl3wtx_pkg::func_type'(func))
            sl3wtx_pkg::FN_CMD: begin
               push         = 1'b1;
               job.pre_rel  = is_open;
               job.post_rel = 1'b1;
               job.data     = command_code;
               open_in      = sl3wtx_pkg::FR_NONE;
            end
            sl3wtx_pkg::FN_WRITE: begin
               push         = 1'b1;
               job.kind     = sl3wtx_pkg::JOB_WRITE;
               job.hdr      = (open_ff != sl3wtx_pkg::FR_WRITE);
               job.pre_rel  = is_open && (open_ff != sl3wtx_pkg::FR_WRITE);
               job.post_rel = last_item;
               open_in      = last_item ? sl3wtx_pkg::FR_NONE : sl3wtx_pkg::FR_WRITE;
            end
            sl3wtx_pkg::FN_READ: begin
               push        = 1'b1;
               job.kind    = sl3wtx_pkg::JOB_READ;
               job.hdr     = (open_ff != sl3wtx_pkg::FR_READ_IDLE) &&
                             (open_ff != sl3wtx_pkg::FR_READ_WAIT);
               job.pre_rel = (open_ff == sl3wtx_pkg::FR_WRITE);
               open_in     = sl3wtx_pkg::FR_READ_WAIT;
               shift_in    = 4'd0;
               count_in    = 2'd0;
            end
            sl3wtx_pkg::FN_SAMPLE: begin
               // samples outside a pending read are dropped
               if (open_ff == sl3wtx_pkg::FR_READ_WAIT) begin
                  if (count_ff == 2'd3) begin
                     push         = 1'b1;
                     job.kind     = sl3wtx_pkg::JOB_NIBBLE;
                     job.data     = {4'd0, shift_next};
                     job.post_rel = last_item;
                     open_in      = last_item ? sl3wtx_pkg::FR_NONE
                                              : sl3wtx_pkg::FR_READ_IDLE;
                     shift_in     = 4'd0;
                     count_in     = 2'd0;
                  end else begin
                     shift_in = shift_next;
                     count_in = count_ff + 2'd1;
                  end
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= sl3wtx_pkg::FR_NONE;
         shift_ff <= 4'd0;
         count_ff <= 2'd0;
      end else begin
         open_ff  <= open_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/sl3wtx_queue.sv
// Short job queue between front and back end.
// Depends on sl3wtx_pkg.
module sl3wtx_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sl3wtx_pkg::job_type  push_job,
   input  logic                 pop,
   output sl3wtx_pkg::job_type  head_job,
   output logic                 empty,
   output logic                 full
);

   localparam int PTR_W = $clog2(sl3wtx_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(sl3wtx_pkg::QUEUE_DEPTH + 1);

   sl3wtx_pkg::job_type mem_ff [sl3wtx_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign empty    = (count_ff == CNT_W'(0));
   assign full     = (count_ff == CNT_W'(sl3wtx_pkg::QUEUE_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/sl3wtx_back.sv
// Back end: expands each job into registered pin actions, one per cycle unless stalled.
// Depends on sl3wtx_pkg.
module sl3wtx_back #(
   parameter int ADDRESS_BITS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sl3wtx_pkg::job_type  head_job,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic                 rsp_bit,
   output logic [3:0]           rsp_nibble,
   output logic                 rsp_last
);

   localparam int CW = sl3wtx_pkg::CNT_W;

   sl3wtx_pkg::phase_type state_ff, state_in, follow;
   sl3wtx_pkg::job_type   job_ff, job_in;
   logic [CW-1:0]         cnt_ff, cnt_in, len, idx;
   logic                  valid_ff, valid_in;
   logic [1:0]            kind_ff, kind_in;
   logic                  bit_ff, bit_in;
   logic [3:0]            nib_ff, nib_in;
   logic                  last_ff, last_in;
   logic                  fire, phase_end, done;
   logic [2:0]            id_code;
   logic [11:0]           cmd_word;
   logic [sl3wtx_pkg::ADDR_MAX_BITS-1:0] addr_ext;

   function automatic sl3wtx_pkg::phase_type after_pre(input sl3wtx_pkg::job_type j);
      after_pre = j.hdr ? sl3wtx_pkg::PH_ID : sl3wtx_pkg::PH_BODY;
   endfunction

   function automatic sl3wtx_pkg::phase_type first_phase(input sl3wtx_pkg::job_type j);
      first_phase = j.pre_rel ? sl3wtx_pkg::PH_PRE : after_pre(j);
   endfunction

   assign fire      = (state_ff != sl3wtx_pkg::PH_IDLE) && (!valid_ff || rsp_ready);
   assign phase_end = (cnt_ff == len - CW'(1));
   assign done      = phase_end && (follow == sl3wtx_pkg::PH_IDLE);
   assign pop       = !empty && ((state_ff == sl3wtx_pkg::PH_IDLE) || (fire && done));
   assign id_code   = (job_ff.kind == sl3wtx_pkg::JOB_READ) ? sl3wtx_pkg::ID_READ
                                                            : sl3wtx_pkg::ID_WRITE;
   assign cmd_word  = {sl3wtx_pkg::ID_COMMAND, 1'b0, job_ff.data};
   assign addr_ext  = sl3wtx_pkg::ADDR_MAX_BITS'(job_ff.addr);
   assign idx       = len - CW'(1) - cnt_ff;   // MSB-first bit position

   // phase length and successor
   always_comb begin
      len    = CW'(1);
      follow = sl3wtx_pkg::PH_IDLE;
      case (state_ff)
         sl3wtx_pkg::PH_PRE: begin
            follow = after_pre(job_ff);
         end
         sl3wtx_pkg::PH_ID: begin
            len    = CW'(3);
            follow = sl3wtx_pkg::PH_ADDR;
         end
         sl3wtx_pkg::PH_ADDR: begin
            len    = CW'(ADDRESS_BITS);
            follow = sl3wtx_pkg::PH_BODY;
         end
         sl3wtx_pkg::PH_BODY: begin
            case (job_ff.kind)
               sl3wtx_pkg::JOB_CMD:    len = CW'(12);
               sl3wtx_pkg::JOB_WRITE:  len = job_ff.both ? CW'(8) : CW'(4);
               sl3wtx_pkg::JOB_READ:   len = CW'(4);
               default:                len = CW'(1);
            endcase
            follow = job_ff.post_rel ? sl3wtx_pkg::PH_POST : sl3wtx_pkg::PH_IDLE;
         end
         default: begin
            follow = sl3wtx_pkg::PH_IDLE;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      cnt_in   = cnt_ff;
      if (pop) begin
         state_in = first_phase(head_job);
         job_in   = head_job;
         cnt_in   = '0;
      end else if (fire) begin
         state_in = phase_end ? follow : state_ff;
         cnt_in   = phase_end ? '0 : cnt_ff + CW'(1);
      end
   end

   // pin action of the current step
   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      bit_in   = bit_ff;
      nib_in   = nib_ff;
      last_in  = last_ff;
      if (fire) begin
         valid_in = 1'b1;
         kind_in  = sl3wtx_pkg::KIND_WRITE;
         bit_in   = 1'b0;
         nib_in   = 4'd0;
         last_in  = done;
         case (state_ff)
            sl3wtx_pkg::PH_PRE, sl3wtx_pkg::PH_POST: begin
               kind_in = sl3wtx_pkg::KIND_RELEASE;
            end
            sl3wtx_pkg::PH_ID: begin
               bit_in = id_code[idx[1:0]];
            end
            sl3wtx_pkg::PH_ADDR: begin
               bit_in = addr_ext[idx[$clog2(sl3wtx_pkg::ADDR_MAX_BITS)-1:0]];
            end
            sl3wtx_pkg::PH_BODY: begin
               case (job_ff.kind)
                  sl3wtx_pkg::JOB_CMD:   bit_in = cmd_word[idx];
                  sl3wtx_pkg::JOB_WRITE: bit_in = job_ff.data[cnt_ff[2:0]];
                  sl3wtx_pkg::JOB_READ:  kind_in = sl3wtx_pkg::KIND_READ;
                  default: begin
                     kind_in = sl3wtx_pkg::KIND_NIBBLE;
                     nib_in  = job_ff.data[3:0];
                  end
               endcase
            end
            default: begin
               valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sl3wtx_pkg::PH_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      kind_ff <= kind_in;
      bit_ff  <= bit_in;
      nib_ff  <= nib_in;
      last_ff <= last_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_bit    = bit_ff;
   assign rsp_nibble = nib_ff;
   assign rsp_last   = last_ff;

endmodule

### design/segment_lcd_three_wire_frame_tx.sv
// Three-wire segment-LCD bus frame transmitter. Each input item (command, byte write,
// read-nibble request or returned read sample) becomes a run of pin actions on the
// result stream: write strobes carrying a data bit, read strobes, chip-select
// releases and assembled read nibbles; tlast marks the final action of an item.
// Frames of the same kind are continued without resending id and address; a frame
// of another kind, or a command, first releases the open one. The result stream
// carries one pin action per cycle while the sink is ready, from the back-end
// sequencer's output register; an item causes 1 to 13 + ADDRESS_BITS actions (19 at
// the default). A four-entry job queue lets the front end keep accepting while
// actions drain; a sample that completes no nibble is taken with no result.
// Depends on sl3wtx_pkg, sl3wtx_front, sl3wtx_queue and sl3wtx_back.
module segment_lcd_three_wire_frame_tx #(
   parameter int ADDRESS_BITS = 6   // 4 to 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command_code[7:0], ram_address[13:8], data_byte[21:14],
   // both_halves[22], sample_bit[23]
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,   // func
   input  logic        req_tlast,   // last_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // data_bit[0], read_nibble[4:1], zero[7:5]
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // last
);

   sl3wtx_pkg::job_type push_job, head_job;
   logic                push, pop, empty, full;
   logic                rsp_bit;
   logic [3:0]          rsp_nibble;

   // front stalls only on a full queue
   assign req_tready = !full;

   sl3wtx_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_tvalid && req_tready),
      .func         (req_tuser),
      .command_code (req_tdata[7:0]),
      .ram_address  (req_tdata[13:8]),
      .data_byte    (req_tdata[21:14]),
      .both_halves  (req_tdata[22]),
      .sample_bit   (req_tdata[23]),
      .last_item    (req_tlast),
      .push         (push),
      .job          (push_job)
   );

   sl3wtx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   sl3wtx_back #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .empty      (empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_bit    (rsp_bit),
      .rsp_nibble (rsp_nibble),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {3'd0, rsp_nibble, rsp_bit};

endmodule

### design/sl3wtx_checker.sv
// Port-level checks of the three-wire LCD frame transmitter, bound to the top level.
// Depends on sl3wtx_pkg and segment_lcd_three_wire_frame_tx_defines.svh.
`include "segment_lcd_three_wire_frame_tx_defines.svh"

module sl3wtx_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast
);

   logic        is_write, is_nibble, stalled;
   logic        non_write, non_nibble, nib_clear, hold_ok;
   logic [10:0] word_ff, word_in;

   assign is_write   = (rsp_tuser == sl3wtx_pkg::KIND_WRITE);
   assign is_nibble  = (rsp_tuser == sl3wtx_pkg::KIND_NIBBLE);
   assign stalled    = rsp_tvalid && !rsp_tready;
   assign non_write  = rsp_tvalid && !is_write;
   assign non_nibble = rsp_tvalid && !is_nibble;
   assign nib_clear  = (rsp_tdata[4:1] == 4'd0);

   // previous result word, compared while the sink stalls
   assign word_in = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign hold_ok = rsp_tvalid && (word_in == word_ff);

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   `SL3WTX_IMPLIES(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[7:5] == 3'd0, "pad bits set")
   `SL3WTX_IMPLIES(a_bit_only_write, clock, reset, non_write, !rsp_tdata[0], "stray data bit")
   `SL3WTX_IMPLIES(a_nibble_only_read, clock, reset, non_nibble, nib_clear, "stray nibble")
   `SL3WTX_ALWAYS(a_stall_hold, clock, reset, !$past(stalled) || hold_ok, "stall broken")

endmodule

bind segment_lcd_three_wire_frame_tx sl3wtx_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
